### src/bftr_pkg.sv
package bftr_pkg;

  localparam int FontWords = 4096;
  localparam int FontAw = $clog2(FontWords);
  localparam int MaxGlyphWidth = 16;
  localparam int MaxGlyphHeight = 32;

  localparam int ApbAw = 4;
  localparam int ApbDw = 32;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_CHAR = 2'd2;

  localparam logic [1:0] REG_GLYPH_WIDTH = 2'd0;
  localparam logic [1:0] REG_GLYPH_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SCREEN_WIDTH = 2'd2;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd3;

  localparam logic [4:0] GW_RESET = 5'd11;
  localparam logic [5:0] GH_RESET = 6'd18;
  localparam logic [9:0] SW_RESET = 10'd320;
  localparam logic [9:0] SH_RESET = 10'd240;

  localparam logic [7:0] CHAR_FIRST = 8'd32;
  localparam logic [7:0] CHAR_LAST = 8'd126;
  localparam logic [7:0] CHAR_SUBST = 8'd63;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [15:0] ROW_MASK_ALL = 16'h8000 | 16'h7FFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [11:0] font_index;
    logic [15:0] font_word;
    logic [9:0]  start_x;
    logic [9:0]  start_y;
    logic [7:0]  char_code;
  } req_t;

  typedef struct packed {
    logic [9:0]  win_x_first;
    logic [9:0]  win_y_first;
    logic [9:0]  win_x_last;
    logic [9:0]  win_y_last;
    logic [4:0]  glyph_row;
    logic [15:0] row_bits;
    logic        last_row;
  } row_t;

  typedef struct packed {
    logic [4:0] gw;
    logic [5:0] gh;
    logic [9:0] sw;
    logic [9:0] sh;
  } cfg_t;

  typedef struct packed {
    logic [15:0] a;
    logic [5:0]  b;
    logic [9:0]  lim;
  } alu_req_t;

  typedef struct packed {
    logic [15:0] sum_sat;
    logic        over;
  } alu_rsp_t;

endpackage

### src/bftr_if.sv
interface bftr_req_if;
  logic           valid;
  logic           ready;
  bftr_pkg::req_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface bftr_row_if;
  logic           valid;
  logic           ready;
  bftr_pkg::row_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

### src/bftr_alu.sv
module bftr_alu (
  input  bftr_pkg::alu_req_t req_i,
  output bftr_pkg::alu_rsp_t rsp_o
);

  logic [16:0] sum;

  assign sum = {1'b0, req_i.a} + {11'b0, req_i.b};
  assign rsp_o.over = (sum > {7'b0, req_i.lim});
  assign rsp_o.sum_sat = sum[16] ? 16'hFFFF : sum[15:0];

endmodule

### src/bftr_font_mem.sv
module bftr_font_mem (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [bftr_pkg::FontAw-1:0] wr_addr_i,
  input  logic [15:0]                wr_data_i,
  input  logic                       rd_en_i,
  input  logic [bftr_pkg::FontAw-1:0] rd_addr_i,
  output logic [15:0]                rd_data_o
);

  logic [15:0] mem_q [bftr_pkg::FontWords];
  logic [15:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### src/bftr_cfg.sv
module bftr_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bftr_pkg::ApbAw-1:0]  paddr,
  input  logic [bftr_pkg::ApbDw-1:0]  pwdata,
  output logic [bftr_pkg::ApbDw-1:0]  prdata,
  output logic                        pready,
  output bftr_pkg::cfg_t              cfg_o
);

  logic [4:0] gw_q;
  logic [5:0] gh_q;
  logic [9:0] sw_q;
  logic [9:0] sh_q;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q <= bftr_pkg::GW_RESET;
      gh_q <= bftr_pkg::GH_RESET;
      sw_q <= bftr_pkg::SW_RESET;
      sh_q <= bftr_pkg::SH_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        bftr_pkg::REG_GLYPH_WIDTH: gw_q <= pwdata[4:0];
        bftr_pkg::REG_GLYPH_HEIGHT: gh_q <= pwdata[5:0];
        bftr_pkg::REG_SCREEN_WIDTH: sw_q <= pwdata[9:0];
        bftr_pkg::REG_SCREEN_HEIGHT: sh_q <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bftr_pkg::REG_GLYPH_WIDTH: prdata = {27'b0, gw_q};
      bftr_pkg::REG_GLYPH_HEIGHT: prdata = {26'b0, gh_q};
      bftr_pkg::REG_SCREEN_WIDTH: prdata = {22'b0, sw_q};
      bftr_pkg::REG_SCREEN_HEIGHT: prdata = {22'b0, sh_q};
      default: prdata = '0;
    endcase
  end

  always_comb begin
    priority if (gw_q == 5'd0) begin
      cfg_o.gw = 5'd1;
    end else if (gw_q > 5'(bftr_pkg::MaxGlyphWidth)) begin
      cfg_o.gw = 5'(bftr_pkg::MaxGlyphWidth);
    end else begin
      cfg_o.gw = gw_q;
    end
    priority if (gh_q == 6'd0) begin
      cfg_o.gh = 6'd1;
    end else if (gh_q > 6'(bftr_pkg::MaxGlyphHeight)) begin
      cfg_o.gh = 6'(bftr_pkg::MaxGlyphHeight);
    end else begin
      cfg_o.gh = gh_q;
    end
    cfg_o.sw = sw_q;
    cfg_o.sh = sh_q;
  end

endmodule

### src/bitmap_font_text_renderer.sv
// Channel | Dir | Beat                 | Accepted when
// req     | in  | load, start or char  | req.valid and req.ready
// row     | out | one glyph row        | row.valid and row.ready
// apb     | in  | register write/read  | psel, penable, pready
//
// A load, a start or an ignored item leaves the sequencer idle; a newline passes
// through the newline state. A drawn character runs cursor layout through the shared
// adder/comparator in the x check, an optional wrap and the y check, then, unless
// stopped there, reads one glyph row per cycle from the font memory read port unless stalled.
// The input is ready only while the sequencer is idle; a stalled row beat holds
// the row loop. Reset clears the cursor and the stop flag and reloads the registers.
module bitmap_font_text_renderer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bftr_pkg::ApbAw-1:0] paddr,
  input  logic [bftr_pkg::ApbDw-1:0] pwdata,
  output logic [bftr_pkg::ApbDw-1:0] prdata,
  output logic                       pready,
  bftr_req_if.sink                   req,
  bftr_row_if.source                 row
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEWLINE,
    ST_XCHK,
    ST_WRAP,
    ST_YCHK,
    ST_ROWS
  } state_e;

  state_e             state_q;
  logic [9:0]         cur_x_q;
  logic [15:0]        cur_y_q;
  logic               stopped_q;
  logic [6:0]         code_idx_q;
  logic [11:0]        base_q;
  logic [4:0]         row_q;
  logic               out_valid_q;
  logic [9:0]         x_first_q;
  logic [9:0]         y_first_q;
  logic [9:0]         x_last_q;
  logic [9:0]         y_last_q;
  logic [4:0]         glyph_row_q;
  logic               last_row_q;
  logic [15:0]        mask_q;

  bftr_pkg::cfg_t     cfg;
  bftr_pkg::alu_req_t alu_req;
  bftr_pkg::alu_rsp_t alu_rsp;

  logic               in_fire;
  logic               issue;
  logic               last_issue;
  logic [11:0]        rd_addr;
  logic [15:0]        rd_data;
  logic               mem_wr;
  logic [12:0]        base_prod;
  logic [10:0]        x_end;
  logic [7:0]         code_sub;
  logic [15:0]        row_mask;

  bftr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bftr_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  bftr_font_mem u_font_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr),
    .wr_addr_i (req.payload.font_index),
    .wr_data_i (req.payload.font_word),
    .rd_en_i   (issue),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign req.ready = (state_q == ST_IDLE);
  assign in_fire = req.valid & req.ready;
  assign mem_wr = in_fire & (req.payload.req_type == bftr_pkg::REQ_LOAD);

  assign issue = (state_q == ST_ROWS) & (~out_valid_q | row.ready);
  assign last_issue = issue & ({1'b0, row_q} == (cfg.gh - 6'd1));
  assign rd_addr = base_q + {7'b0, row_q};
  assign base_prod = {6'b0, code_idx_q} * {7'b0, cfg.gh};
  assign x_end = {1'b0, cur_x_q} + {6'b0, cfg.gw};
  assign row_mask = bftr_pkg::ROW_MASK_ALL << (5'd16 - cfg.gw);

  always_comb begin
    if ((req.payload.char_code < bftr_pkg::CHAR_FIRST) ||
        (req.payload.char_code > bftr_pkg::CHAR_LAST)) begin
      code_sub = bftr_pkg::CHAR_SUBST - bftr_pkg::CHAR_FIRST;
    end else begin
      code_sub = req.payload.char_code - bftr_pkg::CHAR_FIRST;
    end
  end

  always_comb begin
    alu_req.b = cfg.gh;
    unique case (state_q)
      ST_XCHK: begin
        alu_req.a = {6'b0, cur_x_q};
        alu_req.b = {1'b0, cfg.gw};
        alu_req.lim = cfg.sw;
      end
      ST_YCHK: begin
        alu_req.a = cur_y_q;
        alu_req.lim = cfg.sh;
      end
      default: begin
        alu_req.a = cur_y_q;
        alu_req.lim = cfg.sh;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cur_x_q <= '0;
      cur_y_q <= '0;
      stopped_q <= 1'b0;
      code_idx_q <= '0;
      base_q <= '0;
      row_q <= '0;
      out_valid_q <= 1'b0;
      x_first_q <= '0;
      y_first_q <= '0;
      x_last_q <= '0;
      y_last_q <= '0;
      glyph_row_q <= '0;
      last_row_q <= 1'b0;
      mask_q <= '0;
    end else begin
      if (issue) begin
        out_valid_q <= 1'b1;
      end else if (row.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (req.payload.req_type == bftr_pkg::REQ_START) begin
              cur_x_q <= req.payload.start_x;
              cur_y_q <= {6'b0, req.payload.start_y};
              stopped_q <= 1'b0;
            end else if ((req.payload.req_type == bftr_pkg::REQ_CHAR) && !stopped_q) begin
              if (req.payload.char_code == bftr_pkg::CHAR_NEWLINE) begin
                state_q <= ST_NEWLINE;
              end else begin
                code_idx_q <= code_sub[6:0];
                state_q <= ST_XCHK;
              end
            end
          end
        end
        ST_NEWLINE: begin
          cur_x_q <= '0;
          cur_y_q <= alu_rsp.sum_sat;
          state_q <= ST_IDLE;
        end
        ST_XCHK: begin
          base_q <= base_prod[11:0];
          if (alu_rsp.over) begin
            cur_x_q <= '0;
            state_q <= ST_WRAP;
          end else begin
            state_q <= ST_YCHK;
          end
        end
        ST_WRAP: begin
          cur_y_q <= alu_rsp.sum_sat;
          state_q <= ST_YCHK;
        end
        ST_YCHK: begin
          row_q <= '0;
          if (alu_rsp.over) begin
            stopped_q <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_ROWS;
          end
        end
        ST_ROWS: begin
          if (issue) begin
            x_first_q <= cur_x_q;
            y_first_q <= cur_y_q[9:0];
            x_last_q <= cur_x_q + {5'b0, cfg.gw} - 10'd1;
            y_last_q <= cur_y_q[9:0] + {4'b0, cfg.gh} - 10'd1;
            glyph_row_q <= row_q;
            last_row_q <= last_issue;
            mask_q <= row_mask;
            row_q <= row_q + 5'd1;
            if (last_issue) begin
              cur_x_q <= x_end[9:0];
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign row.valid = out_valid_q;
  assign row.payload.win_x_first = x_first_q;
  assign row.payload.win_y_first = y_first_q;
  assign row.payload.win_x_last = x_last_q;
  assign row.payload.win_y_last = y_last_q;
  assign row.payload.glyph_row = glyph_row_q;
  assign row.payload.row_bits = rd_data & mask_q;
  assign row.payload.last_row = last_row_q;

  a_last_row_ends_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_issue |=> (state_q == ST_IDLE) && out_valid_q && last_row_q)
    else $error("last glyph row did not end the character");

  a_rows_start_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_YCHK) && !alu_rsp.over |=> (state_q == ST_ROWS) && (row_q == 5'd0))
    else $error("row loop did not start at row zero");

  a_stop_from_bottom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(stopped_q) |-> $past(state_q) == ST_YCHK)
    else $error("stop flag set outside the bottom edge check");

  a_row_held_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROWS) && !issue |=> $stable(row_q))
    else $error("row counter moved while the output was stalled");

endmodule
